>>> hdl/binary_lifting_lca_core_defines.svh
// Assertion macros for the binary lifting LCA core.
`ifndef BINARY_LIFTING_LCA_CORE_DEFINES_SVH
`define BINARY_LIFTING_LCA_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BL_ASSERT_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("lca check failed");
`define BL_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("lca check failed");
`else
`define BL_ASSERT_IMPL(lbl, a, c)
`define BL_ASSERT_NEXT(lbl, a, c)
`endif
`endif

>>> hdl/blca_pkg.sv
// Shared constants and types for the binary lifting LCA core.
package blca_pkg;
	localparam int NODES     = 1024;
	localparam int LEVELS    = 10;
	localparam int NODE_W    = 10;
	localparam int DEPTH_W   = 11;
	localparam int LVL_W     = 4;
	localparam int ANC_DEPTH = NODES * LEVELS;
	localparam int ANC_AW    = 14;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
	localparam logic [LVL_W-1:0]   TOP_LVL   = LVL_W'(LEVELS - 1);
	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [LVL_W-1:0]   lvl_t;

	// floor(log2(x)) clamped to the top level; x > 0
	function automatic lvl_t lift_lvl(input depth_t x);
		lvl_t r;
		r = '0;
		for (int i = 0; i < DEPTH_W; i++)
			if (x[i]) r = LVL_W'(i);
		if (r > TOP_LVL) r = TOP_LVL;
		return r;
	endfunction

	function automatic logic [ANC_AW-1:0] anc_addr(input node_t n, input lvl_t l);
		return ANC_AW'(n) * ANC_AW'(LEVELS) + ANC_AW'(l);
	endfunction
endpackage

>>> hdl/blca_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module blca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> hdl/binary_lifting_lca_core.sv
// Top level of the binary lifting lowest common ancestor core.
//
//  channel | dir | handshake     | data                  | user
//  s_axis  | in  | tvalid tready | [23:0] node, partner  | req_type
//  m_axis  | out | tvalid tready | [15:0] ancestor       | -
//
// An add of a nonzero node keeps the core busy after the accepting edge: parent
// depth read, depth/level 0 write, then for each higher level an own level j-1
// read, a mid level j-1 read and a level j write. An add of node 0 is dropped
// and the core stays ready.
// A query: depth reads of u and v, lift steps of the deeper node (at most 12 steps
// for the largest depth gap of 2047), a check that ends at once on equal nodes,
// reads of anc[u][j] and anc[v][j] per level walked (at most LEVELS), the final
// parent read, then the result beat. After reset a clearing pass zeroes both RAMs;
// no beat is taken meanwhile. A result waits in the output register; the next
// beat is taken only after it leaves.
module binary_lifting_lca_core
	import blca_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // node[9:0], partner[19:10]
	input  logic        s_axis_tuser,   // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // ancestor[9:0]
);
`include "binary_lifting_lca_core_defines.svh"

	typedef enum logic [11:0] {
		ST_CLR   = 12'b000000000001,
		ST_IDLE  = 12'b000000000010,
		ST_ARD   = 12'b000000000100, // add: read parent depth
		ST_AWR   = 12'b000000001000, // add: write depth, level 0
		ST_AMID  = 12'b000000010000, // add: read own level j-1
		ST_AUP   = 12'b000000100000, // add: read mid level j-1, then write j
		ST_QDEP  = 12'b000001000000, // query: read depth u then v
		ST_QLIFT = 12'b000010000000, // lift u by level k
		ST_QU    = 12'b000100000000, // read anc[u][j]
		ST_QV    = 12'b001000000000, // read anc[v][j], compare
		ST_QFIN  = 12'b010000000000, // read anc[u][0]
		ST_OUT   = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [ANC_AW-1:0] clr_q;
	node_t  u_q, v_q, res_q;
	depth_t du_q, rem_q;
	lvl_t   j_q;
	logic [1:0] ph_q;

	logic dwe, awe;
	logic [NODE_W-1:0] dwa, dra;
	depth_t dwd, drd;
	logic [ANC_AW-1:0] awa, ara;
	node_t awd, ard;

	blca_ram #(.WIDTH(DEPTH_W), .DEPTH(NODES)) u_depth (
		.clk(clk), .we(dwe), .waddr(dwa), .wdata(dwd), .raddr(dra), .rdata(drd));
	blca_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH)) u_anc (
		.clk(clk), .we(awe), .waddr(awa), .wdata(awd), .raddr(ara), .rdata(ard));

	node_t in_node, in_part;
	assign in_node = s_axis_tdata[9:0];
	assign in_part = s_axis_tdata[19:10];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {6'd0, res_q};

	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;

	// ph_q sequences the read steps: 0 issue, 1 data back
	always_comb begin
		dwe = 1'b0; dwa = u_q; dwd = '0; dra = u_q;
		awe = 1'b0; awa = anc_addr(u_q, j_q); awd = '0; ara = anc_addr(u_q, j_q);
		unique case (state_q)
			ST_CLR: begin
				dwe = 1'b1; dwa = clr_q[NODE_W-1:0];
				awe = 1'b1; awa = clr_q;
			end
			ST_ARD: dra = v_q;
			ST_AWR: begin
				dwe = 1'b1;
				dwd = (drd == DEPTH_MAX) ? DEPTH_MAX : drd + 1'b1;
				awe = 1'b1; awa = anc_addr(u_q, '0); awd = v_q;
			end
			ST_AMID: ara = anc_addr(u_q, j_q - 1'b1);
			ST_AUP: begin
				ara = anc_addr(ard, j_q - 1'b1);
				if (ph_q == 2'd1) begin
					awe = 1'b1; awd = ard;
				end
			end
			ST_QDEP: dra = (ph_q == 2'd0) ? u_q : v_q;
			ST_QLIFT: ara = anc_addr(u_q, lift_lvl(rem_q));
			ST_QU: ara = anc_addr(u_q, j_q);
			ST_QV: ara = anc_addr(v_q, j_q);
			ST_QFIN: ara = anc_addr(u_q, '0);
			default: ;
		endcase
	end

	node_t au_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			ph_q    <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ANC_AW'(ANC_DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (acc) begin
					u_q <= in_node; v_q <= in_part; ph_q <= '0;
					if (s_axis_tuser == REQ_ADD) begin
						if (in_node != '0) state_q <= ST_ARD;
					end else state_q <= ST_QDEP;
				end
				ST_ARD: state_q <= ST_AWR;
				ST_AWR: begin
					j_q <= LVL_W'(1);
					state_q <= (LEVELS > 1) ? ST_AMID : ST_IDLE;
				end
				ST_AMID: begin ph_q <= '0; state_q <= ST_AUP; end
				ST_AUP: begin
					if (ph_q == 2'd0) ph_q <= 2'd1;
					else if (j_q == TOP_LVL) state_q <= ST_IDLE;
					else begin j_q <= j_q + 1'b1; state_q <= ST_AMID; end
				end
				ST_QDEP: begin
					ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 1'b1;
					if (ph_q == 2'd1) du_q <= drd;
					if (ph_q == 2'd2) begin
						// du_q ends up holding the depth of the shallower node v
						if (du_q < drd) begin
							u_q <= v_q; v_q <= u_q;
							rem_q <= drd - du_q;
						end else begin
							rem_q <= du_q - drd; du_q <= drd;
						end
						state_q <= ST_QLIFT;
					end
				end
				ST_QLIFT: begin
					if (ph_q == 2'd0) begin
						if (rem_q == '0) begin
							j_q <= (du_q == '0) ? '0 : lift_lvl(du_q);
							if (u_q == v_q) begin res_q <= u_q; state_q <= ST_OUT; end
							else if (du_q == '0) state_q <= ST_QFIN;
							else state_q <= ST_QU;
						end else begin
							ph_q <= 2'd1;
							rem_q <= rem_q - (DEPTH_W'(1) << lift_lvl(rem_q));
						end
					end else begin
						u_q <= ard; ph_q <= '0;
					end
				end
				ST_QU: begin
					if (ph_q == 2'd0) ph_q <= 2'd1;
					else begin au_q <= ard; ph_q <= '0; state_q <= ST_QV; end
				end
				ST_QV: begin
					if (ph_q == 2'd0) ph_q <= 2'd1;
					else begin
						ph_q <= '0;
						if (au_q != ard) begin u_q <= au_q; v_q <= ard; end
						if (j_q == '0) state_q <= ST_QFIN;
						else begin j_q <= j_q - 1'b1; state_q <= ST_QU; end
					end
				end
				ST_QFIN: begin
					if (ph_q == 2'd0) ph_q <= 2'd1;
					else begin res_q <= ard; ph_q <= '0; state_q <= ST_OUT; end
				end
				ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`BL_ASSERT_IMPL(a_ready_idle, s_axis_tready, !m_axis_tvalid)
	`BL_ASSERT_IMPL(a_no_write_query, state_q == ST_QU || state_q == ST_QV, !awe && !dwe)
	`BL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`BL_ASSERT_IMPL(a_phase, state_q == ST_IDLE, ph_q != 2'd3)
endmodule
